### design/quintic_trajectory_sampler_defines.svh
// Assertion macros for the quintic trajectory sampler checker.
// Used by qts_checker only; the macros need clk_i and rst_ni in scope.
`ifndef QUINTIC_TRAJECTORY_SAMPLER_DEFINES_SVH
`define QUINTIC_TRAJECTORY_SAMPLER_DEFINES_SVH

// Concurrent assertion sampled on the rising clock, off during reset.
`define QTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define QTS_ASSERT_NEXT(lbl, pre, post, msg) \
  `QTS_ASSERT(lbl, (pre) |=> (post), msg)

`endif

### design/qts_pkg.sv
// Shared types and constants for the quintic trajectory sampler.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package qts_pkg;

  localparam int SQ       = 28;
  localparam int PERIOD_W = 20;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 20'd20000;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX   = 20'd1000000;

  localparam logic REQ_WAYPOINT = 1'b0;
  localparam logic REQ_TICK     = 1'b1;

  typedef logic signed [63:0] word_t;

  typedef enum logic [2:0] {
    STAT_SAMPLE   = 3'd0,
    STAT_FIRST    = 3'd1,
    STAT_STARTED  = 3'd2,
    STAT_BAD_TIME = 3'd3,
    STAT_BUSY     = 3'd4,
    STAT_IDLE     = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_MULF,
    ALU_MULR,
    ALU_DIV,
    ALU_DIVR
  } alu_op_e;

  typedef enum logic [2:0] {
    AS_IDLE,
    AS_MUL,
    AS_DIV,
    AS_POST,
    AS_DONE
  } alu_state_e;

  typedef enum logic [1:0] {
    C_IDLE,
    C_CALC,
    C_EMIT
  } ctrl_state_e;

  typedef enum logic [5:0] {
    ST_NSAMP,
    ST_T,
    ST_S,
    ST_S2,
    ST_S3,
    ST_S4,
    ST_S5,
    ST_B1,
    ST_B2,
    ST_B3,
    ST_B4,
    ST_B5,
    ST_V1,
    ST_V2,
    ST_V3,
    ST_V4,
    ST_V5,
    ST_A1,
    ST_A2,
    ST_A3,
    ST_A4,
    ST_A5,
    ST_P1,
    ST_P2,
    ST_VL1,
    ST_VL2,
    ST_VL3,
    ST_AC1,
    ST_AC2,
    ST_AC3,
    ST_AC4,
    ST_AC5
  } step_e;

  typedef struct packed {
    logic               start;
    alu_op_e            op;
    word_t              a;
    word_t              b;
  } alu_req_t;

  typedef struct packed {
    logic               done;
    word_t              res;
  } alu_rsp_t;

  typedef struct packed {
    logic               req_type;
    logic [31:0]        waypoint_time_us;
    logic signed [31:0] waypoint_position;
  } in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] sample_position;
    logic signed [31:0] sample_velocity;
    logic signed [31:0] sample_acceleration;
    logic               last_of_segment;
  } out_t;

endpackage
`default_nettype wire

### design/quintic_trajectory_sampler.sv
// Status-only words skip the ALU; segment starts and samples step through the
// shared ALU (each divide walks 64 quotient bits, each multiply one multiplier
// bit a cycle).
// The block takes one word at a time: the next word is taken once the result
// has moved to the output register, and input stalls while busy.
// Reset: asynchronous, active low; no waypoint held, period 20000 us.
`timescale 1ns / 1ps
`default_nettype none
module quintic_trajectory_sampler
  import qts_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire in_t                 in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output out_t                     out_data_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [PERIOD_W-1:0] cfg_data_i
);

  logic [PERIOD_W-1:0] period_q, period_d;
  logic                out_valid_q, out_valid_d;
  out_t                out_data_q;
  logic                idle;
  alu_req_t            alu_req;
  alu_rsp_t            alu_rsp;
  logic                res_valid;
  out_t                res;
  logic                res_take;

  qts_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  qts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .idle_o      (idle),
    .period_i    (period_q),
    .alu_req_o   (alu_req),
    .alu_rsp_i   (alu_rsp),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_take_i  (res_take)
  );

  assign in_stall_o  = !idle;
  assign cfg_ready_o = idle;
  assign res_take    = res_valid && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    period_d = period_q;
    if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_data_i == '0) begin
        period_d = PERIOD_W'(1);
      end else if (cfg_data_i > PERIOD_MAX) begin
        period_d = PERIOD_MAX;
      end else begin
        period_d = cfg_data_i;
      end
    end
    out_valid_d = out_valid_q;
    if (res_take) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= PERIOD_RESET;
      out_valid_q <= 1'b0;
    end else begin
      period_q    <= period_d;
      out_valid_q <= out_valid_d;
    end
  end

  // hold the word while stalled, load on take
  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_data_q <= res;
    end
  end

endmodule
`default_nettype wire

### design/qts_alu.sv
// Shared iterative arithmetic unit: add, subtract, shift-add multiply and
// restoring divide around one 64-bit adder. Depends on qts_pkg.
`timescale 1ns / 1ps
`default_nettype none
module qts_alu
  import qts_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire alu_req_t req_i,
  output alu_rsp_t      rsp_o
);

  alu_state_e  state_q, state_d;
  alu_op_e     op_q, op_d;
  logic        neg_q, neg_d;
  logic [63:0] mc_q, mc_d;
  logic [63:0] mr_q, mr_d;
  logic [63:0] acc_q, acc_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  word_t       res_q, res_d;

  logic [63:0] add_a, add_b, add_y;
  logic        add_sub;
  logic        borrow;
  logic [63:0] post_mag;

  function automatic logic [63:0] mag64(input word_t v);
    mag64 = v[63] ? (~v + 64'd1) : v;
  endfunction

  assign add_y  = add_a + (add_sub ? ~add_b : add_b) + {63'd0, add_sub};
  assign borrow = add_y[63];

  // operand select for the shared adder
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    case (state_q)
      AS_IDLE: begin
        case (req_i.op)
          ALU_ADD: begin
            add_a = req_i.a;
            add_b = req_i.b;
          end
          ALU_SUB: begin
            add_a   = req_i.a;
            add_b   = req_i.b;
            add_sub = 1'b1;
          end
          ALU_DIVR: begin
            add_a = mag64(req_i.a);
            add_b = {1'b0, req_i.b[63:1]};
          end
          default: ;
        endcase
      end
      AS_MUL: begin
        add_a = acc_q;
        add_b = mc_q;
      end
      AS_DIV: begin
        add_a   = {31'd0, rem_q, acc_q[63]};
        add_b   = {32'd0, den_q};
        add_sub = 1'b1;
      end
      AS_POST: begin
        add_a = acc_q;
        add_b = 64'd1 << (SQ - 1);
      end
      default: ;
    endcase
  end

  always_comb begin
    case (op_q)
      ALU_MULF: post_mag = acc_q >> SQ;
      ALU_MULR: post_mag = add_y >> SQ;
      default:  post_mag = acc_q;
    endcase
  end

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    neg_d   = neg_q;
    mc_d    = mc_q;
    mr_d    = mr_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    den_d   = den_q;
    cnt_d   = cnt_q;
    res_d   = res_q;
    case (state_q)
      AS_IDLE: begin
        if (req_i.start) begin
          op_d = req_i.op;
          case (req_i.op)
            ALU_ADD, ALU_SUB: begin
              res_d   = add_y;
              state_d = AS_DONE;
            end
            ALU_MUL, ALU_MULF, ALU_MULR: begin
              mc_d    = mag64(req_i.a);
              mr_d    = mag64(req_i.b);
              acc_d   = '0;
              neg_d   = req_i.a[63] ^ req_i.b[63];
              state_d = AS_MUL;
            end
            ALU_DIV, ALU_DIVR: begin
              acc_d   = (req_i.op == ALU_DIVR) ? add_y : mag64(req_i.a);
              den_d   = req_i.b[31:0];
              rem_d   = '0;
              cnt_d   = '0;
              neg_d   = req_i.a[63];
              state_d = AS_DIV;
            end
            default: state_d = AS_DONE;
          endcase
        end
      end
      AS_MUL: begin
        if (mr_q == '0) begin
          state_d = AS_POST;
        end else begin
          if (mr_q[0]) begin
            acc_d = add_y;
          end
          mc_d = mc_q << 1;
          mr_d = mr_q >> 1;
        end
      end
      AS_DIV: begin
        // quotient bits shift into the dividend register from the bottom
        rem_d = borrow ? {rem_q[30:0], acc_q[63]} : add_y[31:0];
        acc_d = {acc_q[62:0], ~borrow};
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          state_d = AS_POST;
        end
      end
      AS_POST: begin
        res_d   = neg_q ? word_t'(~post_mag + 64'd1) : word_t'(post_mag);
        state_d = AS_DONE;
      end
      AS_DONE: state_d = AS_IDLE;
      default: state_d = AS_IDLE;
    endcase
  end

  always_comb begin
    rsp_o.done = (state_q == AS_DONE);
    rsp_o.res  = res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= AS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    neg_q <= neg_d;
    mc_q  <= mc_d;
    mr_q  <= mr_d;
    acc_q <= acc_d;
    rem_q <= rem_d;
    den_q <= den_d;
    cnt_q <= cnt_d;
    res_q <= res_d;
  end

endmodule
`default_nettype wire

### design/qts_ctrl.sv
// Sequencer and segment state: decodes words, steps the shared ALU through
// the quintic shape and its derivatives. Depends on qts_pkg.
`timescale 1ns / 1ps
`default_nettype none
module qts_ctrl
  import qts_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire in_t                 in_data_i,
  output logic                     idle_o,
  input  wire logic [PERIOD_W-1:0] period_i,
  output alu_req_t                 alu_req_o,
  input  wire alu_rsp_t            alu_rsp_i,
  output logic                     res_valid_o,
  output out_t                     res_o,
  input  wire logic                res_take_i
);

  localparam word_t K6    = 64'sd6;
  localparam word_t K10   = 64'sd10;
  localparam word_t K15   = 64'sd15;
  localparam word_t K30   = 64'sd30;
  localparam word_t K60   = 64'sd60;
  localparam word_t K120  = 64'sd120;
  localparam word_t K180  = 64'sd180;
  localparam word_t US    = 64'sd1000000;
  localparam word_t ONE_Q = 64'sd1 << SQ;
  localparam logic [63:0] ACC_LIMIT = 64'd1 << 43;

  ctrl_state_e        cstate_q, cstate_d;
  step_e              step_q, step_d;
  logic               wait_q, wait_d;
  status_e            stat_q, stat_d;

  logic               have_q, have_d;
  logic [31:0]        prior_time_q, prior_time_d;
  logic signed [31:0] prior_pos_q, prior_pos_d;
  logic signed [31:0] start_q, start_d;
  logic signed [32:0] delta_q, delta_d;
  logic [31:0]        dur_q, dur_d;
  logic [31:0]        total_q, total_d;
  logic [31:0]        idx_q, idx_d;

  logic [SQ:0]        s_q, s_d, s2_q, s2_d, s3_q, s3_d, s4_q, s4_d, s5_q, s5_d;
  logic signed [32:0] b_q, b_d, v_q, v_d, a_q, a_d;
  word_t              k1_q, k1_d, k2_q, k2_d;
  logic signed [31:0] pos_q, pos_d, vel_q, vel_d, acc_q, acc_d;
  logic               last_q, last_d;

  logic [32:0]        j;
  word_t              res;
  logic [63:0]        res_mag;

  function automatic logic signed [31:0] sat32(input word_t v);
    if (v > 64'sd2147483647) begin
      sat32 = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  assign j       = {1'b0, idx_q} + 33'd1;
  assign res     = alu_rsp_i.res;
  assign res_mag = res[63] ? (~res + 64'd1) : res;

  // outputs: ALU request and result word
  always_comb begin
    idle_o          = (cstate_q == C_IDLE);
    alu_req_o.start = (cstate_q == C_CALC) && !wait_q;
    alu_req_o.op    = ALU_ADD;
    alu_req_o.a     = '0;
    alu_req_o.b     = '0;
    case (step_q)
      ST_NSAMP: begin
        alu_req_o.op = ALU_DIV;
        alu_req_o.a  = 64'(dur_q);
        alu_req_o.b  = 64'(period_i);
      end
      ST_T: begin
        alu_req_o.op = ALU_MUL;
        alu_req_o.a  = 64'(j);
        alu_req_o.b  = 64'(period_i);
      end
      ST_S: begin
        alu_req_o.op = ALU_DIV;
        alu_req_o.a  = k1_q << SQ;
        alu_req_o.b  = 64'(dur_q);
      end
      ST_S2: begin
        alu_req_o.op = ALU_MULF;
        alu_req_o.a  = 64'(s_q);
        alu_req_o.b  = 64'(s_q);
      end
      ST_S3: begin
        alu_req_o.op = ALU_MULF;
        alu_req_o.a  = 64'(s2_q);
        alu_req_o.b  = 64'(s_q);
      end
      ST_S4: begin
        alu_req_o.op = ALU_MULF;
        alu_req_o.a  = 64'(s3_q);
        alu_req_o.b  = 64'(s_q);
      end
      ST_S5: begin
        alu_req_o.op = ALU_MULF;
        alu_req_o.a  = 64'(s4_q);
        alu_req_o.b  = 64'(s_q);
      end
      ST_B1: begin
        alu_req_o.op = ALU_MUL;
        alu_req_o.a  = 64'(s3_q);
        alu_req_o.b  = K10;
      end
      ST_B2: begin
        alu_req_o.op = ALU_MUL;
        alu_req_o.a  = 64'(s4_q);
        alu_req_o.b  = K15;
      end
      ST_B4: begin
        alu_req_o.op = ALU_MUL;
        alu_req_o.a  = 64'(s5_q);
        alu_req_o.b  = K6;
      end
      ST_V1: begin
        alu_req_o.op = ALU_MUL;
        alu_req_o.a  = 64'(s2_q);
        alu_req_o.b  = K30;
      end
      ST_V2: begin
        alu_req_o.op = ALU_MUL;
        alu_req_o.a  = 64'(s3_q);
        alu_req_o.b  = K60;
      end
      ST_V4: begin
        alu_req_o.op = ALU_MUL;
        alu_req_o.a  = 64'(s4_q);
        alu_req_o.b  = K30;
      end
      ST_A1: begin
        alu_req_o.op = ALU_MUL;
        alu_req_o.a  = 64'(s_q);
        alu_req_o.b  = K60;
      end
      ST_A2: begin
        alu_req_o.op = ALU_MUL;
        alu_req_o.a  = 64'(s2_q);
        alu_req_o.b  = K180;
      end
      ST_A4: begin
        alu_req_o.op = ALU_MUL;
        alu_req_o.a  = 64'(s3_q);
        alu_req_o.b  = K120;
      end
      ST_B3, ST_V3, ST_A3: begin
        alu_req_o.op = ALU_SUB;
        alu_req_o.a  = k1_q;
        alu_req_o.b  = k2_q;
      end
      ST_B5, ST_V5, ST_A5: begin
        alu_req_o.op = ALU_ADD;
        alu_req_o.a  = k1_q;
        alu_req_o.b  = k2_q;
      end
      ST_P1: begin
        alu_req_o.op = ALU_MULR;
        alu_req_o.a  = 64'(delta_q);
        alu_req_o.b  = 64'(b_q);
      end
      ST_P2: begin
        alu_req_o.op = ALU_ADD;
        alu_req_o.a  = k1_q;
        alu_req_o.b  = 64'(start_q);
      end
      ST_VL1: begin
        alu_req_o.op = ALU_MULR;
        alu_req_o.a  = 64'(delta_q);
        alu_req_o.b  = 64'(v_q);
      end
      ST_AC1: begin
        alu_req_o.op = ALU_MULR;
        alu_req_o.a  = 64'(delta_q);
        alu_req_o.b  = 64'(a_q);
      end
      ST_VL2, ST_AC2, ST_AC4: begin
        alu_req_o.op = ALU_MUL;
        alu_req_o.a  = k1_q;
        alu_req_o.b  = US;
      end
      ST_VL3, ST_AC3, ST_AC5: begin
        alu_req_o.op = ALU_DIVR;
        alu_req_o.a  = k1_q;
        alu_req_o.b  = 64'(dur_q);
      end
      default: ;
    endcase

    res_valid_o = (cstate_q == C_EMIT);
    res_o.status = stat_q;
    if (stat_q == STAT_SAMPLE) begin
      res_o.sample_position     = pos_q;
      res_o.sample_velocity     = vel_q;
      res_o.sample_acceleration = acc_q;
      res_o.last_of_segment     = last_q;
    end else begin
      res_o.sample_position     = '0;
      res_o.sample_velocity     = '0;
      res_o.sample_acceleration = '0;
      res_o.last_of_segment     = 1'b0;
    end
  end

  // next state: decode, write back ALU results, advance steps
  always_comb begin
    cstate_d     = cstate_q;
    step_d       = step_q;
    wait_d       = wait_q;
    stat_d       = stat_q;
    have_d       = have_q;
    prior_time_d = prior_time_q;
    prior_pos_d  = prior_pos_q;
    start_d      = start_q;
    delta_d      = delta_q;
    dur_d        = dur_q;
    total_d      = total_q;
    idx_d        = idx_q;
    s_d          = s_q;
    s2_d         = s2_q;
    s3_d         = s3_q;
    s4_d         = s4_q;
    s5_d         = s5_q;
    b_d          = b_q;
    v_d          = v_q;
    a_d          = a_q;
    k1_d         = k1_q;
    k2_d         = k2_q;
    pos_d        = pos_q;
    vel_d        = vel_q;
    acc_d        = acc_q;
    last_d       = last_q;
    case (cstate_q)
      C_IDLE: begin
        if (in_valid_i) begin
          wait_d   = 1'b0;
          cstate_d = C_EMIT;
          if (in_data_i.req_type == REQ_TICK) begin
            if (idx_q < total_q) begin
              stat_d   = STAT_SAMPLE;
              step_d   = ST_T;
              cstate_d = C_CALC;
            end else begin
              stat_d = STAT_IDLE;
            end
          end else if (idx_q < total_q) begin
            stat_d = STAT_BUSY;
          end else if (!have_q) begin
            have_d       = 1'b1;
            prior_time_d = in_data_i.waypoint_time_us;
            prior_pos_d  = in_data_i.waypoint_position;
            stat_d       = STAT_FIRST;
          end else if (in_data_i.waypoint_time_us <= prior_time_q) begin
            stat_d = STAT_BAD_TIME;
          end else begin
            start_d      = prior_pos_q;
            delta_d      = {in_data_i.waypoint_position[31], in_data_i.waypoint_position}
                         - {prior_pos_q[31], prior_pos_q};
            dur_d        = in_data_i.waypoint_time_us - prior_time_q;
            idx_d        = '0;
            prior_time_d = in_data_i.waypoint_time_us;
            prior_pos_d  = in_data_i.waypoint_position;
            stat_d       = STAT_STARTED;
            step_d       = ST_NSAMP;
            cstate_d     = C_CALC;
          end
        end
      end
      C_CALC: begin
        if (!wait_q) begin
          wait_d = 1'b1;
        end else if (alu_rsp_i.done) begin
          wait_d = 1'b0;
          step_d = step_e'(step_q + 6'd1);
          case (step_q)
            ST_NSAMP: begin
              total_d  = res[31:0];
              cstate_d = C_EMIT;
            end
            ST_T:   k1_d = (res > 64'(dur_q)) ? 64'(dur_q) : res;
            ST_S:   s_d  = res[SQ:0];
            ST_S2:  s2_d = res[SQ:0];
            ST_S3:  s3_d = res[SQ:0];
            ST_S4:  s4_d = res[SQ:0];
            ST_S5:  s5_d = res[SQ:0];
            ST_B5: begin
              // clamp the blend to [0, 1]
              if (res[63]) begin
                b_d = '0;
              end else if (res > ONE_Q) begin
                b_d = ONE_Q[32:0];
              end else begin
                b_d = res[32:0];
              end
            end
            ST_V5:  v_d   = res[32:0];
            ST_A5:  a_d   = res[32:0];
            ST_P2:  pos_d = sat32(res);
            ST_VL3: vel_d = sat32(res);
            ST_AC3: begin
              k1_d = res;
              // far out of range: saturate and skip the last scaling
              if (res_mag > ACC_LIMIT) begin
                acc_d    = res[63] ? 32'sh80000000 : 32'sh7fffffff;
                idx_d    = j[31:0];
                last_d   = (j[31:0] == total_q);
                cstate_d = C_EMIT;
              end
            end
            ST_AC5: begin
              acc_d    = sat32(res);
              idx_d    = j[31:0];
              last_d   = (j[31:0] == total_q);
              cstate_d = C_EMIT;
            end
            ST_B2, ST_B4, ST_V2, ST_V4, ST_A2, ST_A4: k2_d = res;
            default: k1_d = res;
          endcase
        end
      end
      C_EMIT: begin
        if (res_take_i) begin
          cstate_d = C_IDLE;
        end
      end
      default: cstate_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cstate_q     <= C_IDLE;
      step_q       <= ST_NSAMP;
      wait_q       <= 1'b0;
      stat_q       <= STAT_IDLE;
      have_q       <= 1'b0;
      prior_time_q <= '0;
      prior_pos_q  <= '0;
      start_q      <= '0;
      delta_q      <= '0;
      dur_q        <= '0;
      total_q      <= '0;
      idx_q        <= '0;
    end else begin
      cstate_q     <= cstate_d;
      step_q       <= step_d;
      wait_q       <= wait_d;
      stat_q       <= stat_d;
      have_q       <= have_d;
      prior_time_q <= prior_time_d;
      prior_pos_q  <= prior_pos_d;
      start_q      <= start_d;
      delta_q      <= delta_d;
      dur_q        <= dur_d;
      total_q      <= total_d;
      idx_q        <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q    <= s_d;
    s2_q   <= s2_d;
    s3_q   <= s3_d;
    s4_q   <= s4_d;
    s5_q   <= s5_d;
    b_q    <= b_d;
    v_q    <= v_d;
    a_q    <= a_d;
    k1_q   <= k1_d;
    k2_q   <= k2_d;
    pos_q  <= pos_d;
    vel_q  <= vel_d;
    acc_q  <= acc_d;
    last_q <= last_d;
  end

endmodule
`default_nettype wire

### design/qts_checker.sv
// Port-level checker for the quintic trajectory sampler, bound to the top.
// Depends on qts_pkg and quintic_trajectory_sampler_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "quintic_trajectory_sampler_defines.svh"
module qts_checker
  import qts_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_stall_o,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire out_t out_data_o
);

  // a word taken in makes the block busy in the next cycle
  `QTS_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "accept without busy")

  `QTS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "output word dropped")

  `QTS_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(out_data_o), "output word changed")

  // anything but a sample carries zero fields and no last flag
  `QTS_ASSERT(a_zero_fields, out_valid_o && (out_data_o.status != STAT_SAMPLE) |-> (out_data_o.sample_position == 0) && (out_data_o.sample_velocity == 0) && (out_data_o.sample_acceleration == 0) && !out_data_o.last_of_segment, "non-sample word carries data")

endmodule

bind quintic_trajectory_sampler qts_checker u_qts_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire
